// ===== rtl/core/lcg_pkg.sv =====
// ----------------------------------------------------------------------------
// lcg_pkg
// Shared constants, types and register codes of the life cell generation
// stream core.
// ----------------------------------------------------------------------------
package lcg_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int CFG_W     = 11;
  localparam int XW        = 10;
  localparam int YW        = 10;
  localparam int IN_ROW_W  = 11;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int MAX_DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int DIM_BITS  = $clog2(MAX_DIM + 1);
  localparam int DIM_W     = (DIM_BITS > CFG_W) ? DIM_BITS : CFG_W;

  localparam int MIN_WIDTH    = 3;
  localparam int MIN_HEIGHT   = 2;
  localparam int RESET_WIDTH  = 64;
  localparam int RESET_HEIGHT = 64;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;

  localparam int WIN_CELLS = 2;

  typedef enum logic [0:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } reg_idx_e;

  typedef logic [2:0] win_col_t;

  typedef struct packed {
    logic shift;
    logic kill;
  } cell_ctrl_t;

  typedef struct packed {
    logic             en;
    logic [COL_W-1:0] addr;
    logic [1:0]       data;
  } line_wr_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic             bot;
    logic             has_mid;
    logic             has_top;
    logic             col_zero;
    logic             emit;
    logic             last;
    logic [COL_W-1:0] oc;
    logic [YW-1:0]    orow;
  } b_item_t;

endpackage

// ===== rtl/core/lcg_stream_if.sv =====
// ----------------------------------------------------------------------------
// lcg_stream_if
// Valid/ready stream interfaces for the cell input and the result output.
// ----------------------------------------------------------------------------
interface lcg_in_if;
  logic valid;
  logic ready;
  logic mode;
  logic alive;

  modport source (output valid, output mode, output alive, input ready);
  modport sink   (input valid, input mode, input alive, output ready);
endinterface

interface lcg_out_if import lcg_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [XW-1:0] cell_x;
  logic [YW-1:0] cell_y;
  logic          next_alive;
  logic          last;

  modport source (output valid, output cell_x, output cell_y, output next_alive,
                  output last, input ready);
  modport sink   (input valid, input cell_x, input cell_y, input next_alive,
                  input last, output ready);
endinterface

// ===== rtl/core/lcg_line_mem.sv =====
// ----------------------------------------------------------------------------
// lcg_line_mem
// Two-row line memory, one entry per column, with write-first bypass and a
// clearing sweep after reset.
// ----------------------------------------------------------------------------
module lcg_line_mem import lcg_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [COL_W-1:0] rd_addr_i,
  input  line_wr_t         wr_i,
  output logic [1:0]       rd_data_o,
  output logic             busy_o
);

  logic [1:0]       mem_q [MAX_WIDTH];
  logic [1:0]       rd_q;
  logic [1:0]       byp_data_q;
  logic             byp_q;
  logic [COL_W:0]   clr_q;
  logic [COL_W:0]   clr_d;
  logic             we;
  logic [COL_W-1:0] wa;
  logic [1:0]       wd;

  assign busy_o = (clr_q < (COL_W + 1)'(MAX_WIDTH));
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;
  assign we     = busy_o || wr_i.en;
  assign wa     = busy_o ? clr_q[COL_W-1:0] : wr_i.addr;
  assign wd     = busy_o ? 2'b00 : wr_i.data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
      byp_q <= 1'b0;
    end else begin
      clr_q <= clr_d;
      if (rd_en_i) begin
        byp_q <= we && (wa == rd_addr_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[wa] <= wd;
    end
    if (rd_en_i) begin
      rd_q       <= mem_q[rd_addr_i];
      byp_data_q <= wd;
    end
  end

  assign rd_data_o = byp_q ? byp_data_q : rd_q;

endmodule

// ===== rtl/core/lcg_window_cell.sv =====
// ----------------------------------------------------------------------------
// lcg_window_cell
// One column of the neighborhood window, shifted on from its neighbor.
// ----------------------------------------------------------------------------
module lcg_window_cell import lcg_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  win_col_t   col_i,
  output win_col_t   col_o
);

  win_col_t col_q;
  win_col_t col_d;

  always_comb begin
    col_d = col_q;
    if (ctrl_i.shift) begin
      col_d = ctrl_i.kill ? '0 : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

// ===== rtl/core/lcg_rule.sv =====
// ----------------------------------------------------------------------------
// lcg_rule
// Neighbor count and B3/S23 decision for the center of a 3x3 window.
// ----------------------------------------------------------------------------
module lcg_rule import lcg_pkg::*; (
  input  logic [8:0] win_i,
  output logic       next_alive_o
);

  logic [3:0] total;
  logic [3:0] nbrs;
  logic       center;

  always_comb begin
    total = '0;
    for (int i = 0; i < 9; i++) begin
      total = total + 4'(win_i[i]);
    end
  end

  assign center       = win_i[4];
  assign nbrs         = total - 4'(center);
  assign next_alive_o = (nbrs == 4'd3) || (center && (nbrs == 4'd2));

endmodule

// ===== rtl/core/life_cell_generation_stream_core.sv =====
// ----------------------------------------------------------------------------
// life_cell_generation_stream_core
// Streaming B3/S23 generation unit with line memory and a chain of window
// column cells.
// ----------------------------------------------------------------------------
// Cells of the previous generation enter one per transaction in raster order,
// and the block sustains one transaction per cycle on both sides unless the
// output stalls; an accepted item waits in the b stage register until it moves
// to the output register. Results trail the input by grid_width+1 items, so
// grid_width+1 drain transactions after the grid complete a generation. The
// rate is set by the line memory, read once and written once per cycle with a
// write-first bypass. After reset the line memory is cleared one entry per
// cycle while no item is accepted; register writes are taken at any time.
module life_cell_generation_stream_core import lcg_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  lcg_in_if.sink            in_ch,
  lcg_out_if.source         out_ch,
  input  logic              psel_i,
  input  logic              penable_i,
  input  logic              pwrite_i,
  input  logic [APB_AW-1:0] paddr_i,
  input  logic [APB_DW-1:0] pwdata_i,
  output logic [APB_DW-1:0] prdata_o,
  output logic              pready_o
);

  logic [CFG_W-1:0]    width_q;
  logic [CFG_W-1:0]    height_q;
  logic [DIM_W-1:0]    w_eff;
  logic [DIM_W-1:0]    h_eff;
  logic [DIM_W-1:0]    width_x;
  logic [DIM_W-1:0]    height_x;
  reg_idx_e            reg_idx;
  logic                cfg_wr;

  logic [COL_W-1:0]    ic_q, ic_d;
  logic [IN_ROW_W-1:0] ir_q, ir_d;
  logic [COL_W-1:0]    oc_q, oc_d;
  logic [YW-1:0]       orow_q, orow_d;
  logic [DIM_W-1:0]    ic_inc, oc_inc, orow_inc, ir_x;
  logic                emit, last;

  logic                busy;
  logic                in_ready;
  logic                in_fire;
  b_item_t             a_item;
  b_item_t             b_q;
  logic                b_valid_q;
  logic                b_adv;
  logic [1:0]          rd_data;
  line_wr_t            line_wr;
  logic                top, mid;
  win_col_t            col;
  win_col_t            cell_q [WIN_CELLS];
  logic [8:0]          win_out;
  logic                next_alive;

  logic                out_valid_q;
  logic [XW-1:0]       out_x_q;
  logic [YW-1:0]       out_y_q;
  logic                out_alive_q;
  logic                out_last_q;

  assign reg_idx  = reg_idx_e'(paddr_i[2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= CFG_W'(RESET_WIDTH);
      height_q <= CFG_W'(RESET_HEIGHT);
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_GRID_WIDTH:  width_q  <= pwdata_i[CFG_W-1:0];
        REG_GRID_HEIGHT: height_q <= pwdata_i[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_GRID_WIDTH:  prdata_o = APB_DW'(width_q);
      REG_GRID_HEIGHT: prdata_o = APB_DW'(height_q);
      default:         prdata_o = '0;
    endcase
  end

  assign width_x  = DIM_W'(width_q);
  assign height_x = DIM_W'(height_q);

  always_comb begin
    if (width_x < DIM_W'(MIN_WIDTH)) begin
      w_eff = DIM_W'(MIN_WIDTH);
    end else if (width_x > DIM_W'(MAX_WIDTH)) begin
      w_eff = DIM_W'(MAX_WIDTH);
    end else begin
      w_eff = width_x;
    end
    if (height_x < DIM_W'(MIN_HEIGHT)) begin
      h_eff = DIM_W'(MIN_HEIGHT);
    end else if (height_x > DIM_W'(MAX_HEIGHT)) begin
      h_eff = DIM_W'(MAX_HEIGHT);
    end else begin
      h_eff = height_x;
    end
  end

  assign ir_x     = DIM_W'(ir_q);
  assign ic_inc   = DIM_W'(ic_q) + 1'b1;
  assign oc_inc   = DIM_W'(oc_q) + 1'b1;
  assign orow_inc = DIM_W'(orow_q) + 1'b1;
  assign emit     = (ir_q >= IN_ROW_W'(2)) || ((ir_q == IN_ROW_W'(1)) && (ic_q != '0));
  assign last     = emit && (orow_inc >= h_eff) && (oc_inc >= w_eff);

  assign b_adv    = b_valid_q && (!b_q.emit || !out_valid_q || out_ch.ready);
  assign in_ready = !busy && (!b_valid_q || b_adv);
  assign in_fire  = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    a_item          = '0;
    a_item.col      = ic_q;
    a_item.bot      = !in_ch.mode && (ir_x < h_eff) && in_ch.alive;
    a_item.has_mid  = (ir_q != '0);
    a_item.has_top  = (ir_q >= IN_ROW_W'(2));
    a_item.col_zero = (ic_q == '0);
    a_item.emit     = emit;
    a_item.last     = last;
    a_item.oc       = oc_q;
    a_item.orow     = orow_q;
  end

  always_comb begin
    ic_d   = ic_q;
    ir_d   = ir_q;
    oc_d   = oc_q;
    orow_d = orow_q;
    if (in_fire) begin
      if (emit) begin
        if (oc_inc >= w_eff) begin
          oc_d   = '0;
          orow_d = orow_q + 1'b1;
        end else begin
          oc_d = COL_W'(oc_inc);
        end
      end
      if (last) begin
        ic_d   = '0;
        ir_d   = '0;
        oc_d   = '0;
        orow_d = '0;
      end else if (ic_inc >= w_eff) begin
        ic_d = '0;
        ir_d = ir_q + 1'b1;
      end else begin
        ic_d = COL_W'(ic_inc);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ic_q      <= '0;
      ir_q      <= '0;
      oc_q      <= '0;
      orow_q    <= '0;
      b_valid_q <= 1'b0;
    end else begin
      ic_q   <= ic_d;
      ir_q   <= ir_d;
      oc_q   <= oc_d;
      orow_q <= orow_d;
      if (in_fire) begin
        b_valid_q <= 1'b1;
      end else if (b_adv) begin
        b_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      b_q <= a_item;
    end
  end

  lcg_line_mem u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_fire),
    .rd_addr_i (ic_q),
    .wr_i      (line_wr),
    .rd_data_o (rd_data),
    .busy_o    (busy)
  );

  assign top = b_q.has_top && rd_data[0];
  assign mid = b_q.has_mid && rd_data[1];
  assign col = {b_q.bot, mid, top};

  always_comb begin
    line_wr.en   = b_adv;
    line_wr.addr = b_q.col;
    line_wr.data = {b_q.bot, mid};
  end

  for (genvar i = 0; i < WIN_CELLS; i++) begin : g_cell
    cell_ctrl_t ctrl;
    win_col_t   din;

    assign ctrl.shift = b_adv;
    assign ctrl.kill  = b_q.last || ((i != WIN_CELLS - 1) && b_q.col_zero);
    assign din        = (i == WIN_CELLS - 1) ? col : cell_q[(i + 1) % WIN_CELLS];

    lcg_window_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .ctrl_i (ctrl),
      .col_i  (din),
      .col_o  (cell_q[i])
    );
  end

  assign win_out = {cell_q[0], cell_q[1], (b_q.col_zero ? 3'b000 : col)};

  lcg_rule u_rule (
    .win_i        (win_out),
    .next_alive_o (next_alive)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (b_adv && b_q.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_adv && b_q.emit) begin
      out_x_q     <= XW'(b_q.oc);
      out_y_q     <= b_q.orow;
      out_alive_q <= next_alive;
      out_last_q  <= b_q.last;
    end
  end

  assign out_ch.valid      = out_valid_q;
  assign out_ch.cell_x     = out_x_q;
  assign out_ch.cell_y     = out_y_q;
  assign out_ch.next_alive = out_alive_q;
  assign out_ch.last       = out_last_q;

endmodule

// ===== rtl/core/lcg_checker.sv =====
// ----------------------------------------------------------------------------
// lcg_checker
// Port-level assertions on result order and register access of the core.
// ----------------------------------------------------------------------------
module lcg_checker import lcg_pkg::*; (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input logic [XW-1:0]     cell_x_i,
  input logic [YW-1:0]     cell_y_i,
  input logic              next_alive_i,
  input logic              last_i,
  input logic              psel_i,
  input logic              penable_i,
  input logic              pwrite_i,
  input logic [APB_AW-1:0] paddr_i,
  input logic [APB_DW-1:0] pwdata_i,
  input logic [APB_DW-1:0] prdata_i,
  input logic              pready_i
);

  logic out_fire;
  logic cfg_wr;

  assign out_fire = out_valid_i && out_ready_i;
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_i;

  // A stalled result keeps its payload until the sink takes it.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cell_x_i)
      && $stable(cell_y_i) && $stable(next_alive_i) && $stable(last_i))
    else $error("result payload changed while stalled");

  // Back-to-back results step one column or restart a row.
  a_col_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire ##1 out_fire |-> (cell_x_i == $past(cell_x_i) + 1'b1) || (cell_x_i == '0))
    else $error("result column does not follow the previous one");

  // Within a row the row index stays put.
  a_row_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire ##1 (out_fire && (cell_x_i != '0)) |-> cell_y_i == $past(cell_y_i))
    else $error("result row changed inside a row");

  // A register reads back what was last written to it.
  a_reg_rdback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr ##1 (psel_i && (paddr_i[2] == $past(paddr_i[2])))
      |-> prdata_i == {{(APB_DW - CFG_W){1'b0}}, $past(pwdata_i[CFG_W-1:0])})
    else $error("register read back differs from written value");

endmodule

bind life_cell_generation_stream_core lcg_checker u_lcg_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_ch.valid),
  .out_ready_i  (out_ch.ready),
  .cell_x_i     (out_ch.cell_x),
  .cell_y_i     (out_ch.cell_y),
  .next_alive_i (out_ch.next_alive),
  .last_i       (out_ch.last),
  .psel_i       (psel_i),
  .penable_i    (penable_i),
  .pwrite_i     (pwrite_i),
  .paddr_i      (paddr_i),
  .pwdata_i     (pwdata_i),
  .prdata_i     (prdata_o),
  .pready_i     (pready_o)
);
